// File: design/integer_to_ascii_formatter_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Concurrent checks clocked on clk and muted while arst_n is low.
// ------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ITAF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ITAF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/itaf_pkg.sv
// ------------------------------------------------------------------------
// itaf_pkg
// Shared types, character codes and helpers of the integer to ASCII formatter.
// ------------------------------------------------------------------------
package itaf_pkg;

	// Mode codes of the action field.
	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	// ASCII codes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_F     = 8'h66;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	// Shift-and-add-3 constants of the binary to BCD conversion.
	localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
	localparam logic [3:0] BCD_ADJ     = 4'd3;
	localparam logic [3:0] DIGIT_TEN   = 4'd10;

	// Bits of the magnitude consumed per conversion cycle.
	localparam int BITS_PER_STEP = 4;

	// Classification that travels with a word from the front to the back.
	typedef struct packed {
		logic hex;
		logic neg;
	} itaf_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_SIGN,
		ST_EMIT
	} itaf_state_t;

	// One digit (0 to 15) to its lowercase ASCII code.
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_A + {4'd0, d - DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

// File: design/itaf_front.sv
// ------------------------------------------------------------------------
// itaf_front
// Accepts words, classifies sign and mode, and queues the magnitude.
// ------------------------------------------------------------------------
module itaf_front #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  action,
	input  logic [WORD_BITS-1:0]  value,
	output logic                  q_valid,
	input  logic                  q_take,
	output itaf_pkg::itaf_ctl_t   q_ctl,
	output logic [WORD_BITS-1:0]  q_mag
);
	import itaf_pkg::*;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	itaf_ctl_t            ctl_mem_q [QDEPTH];
	logic [WORD_BITS-1:0] mag_mem_q [QDEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	itaf_ctl_t            in_ctl;
	logic [WORD_BITS-1:0] in_mag;
	logic                 wr_en;
	logic                 rd_en;

	// A decimal word with its top bit set is negative; its magnitude is the
	// unsigned two's complement, which also covers the most negative value.
	always_comb begin
		in_ctl.hex = (action == MODE_HEX);
		in_ctl.neg = (action == MODE_DEC) && value[WORD_BITS-1];
		in_mag     = in_ctl.neg ? (~value + WORD_BITS'(1)) : value;
	end

	assign full    = (count_q == CNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;
	assign q_ctl   = ctl_mem_q[rd_ptr_q];
	assign q_mag   = mag_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctl_mem_q[wr_ptr_q] <= in_ctl;
			mag_mem_q[wr_ptr_q] <= in_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: design/itaf_back.sv
// ------------------------------------------------------------------------
// itaf_back
// Converts a queued magnitude to digits and emits characters one by one.
// ------------------------------------------------------------------------
module itaf_back #(
	parameter int WORD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_take,
	input  itaf_pkg::itaf_ctl_t   q_ctl,
	input  logic [WORD_BITS-1:0]  q_mag,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            char_code,
	output logic                  last
);
	import itaf_pkg::*;

	// Decimal digits needed for 2^WORD_BITS - 1 (1233 / 4096 ~ log10 2).
	localparam int NDIG  = ((WORD_BITS * 1233) >> 12) + 1;
	localparam int DIG_W = NDIG * 4;
	localparam int STEPS = (WORD_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PW    = STEPS * BITS_PER_STEP;
	localparam int CW    = $clog2(STEPS + 1);
	localparam int IW    = $clog2(NDIG);

	itaf_state_t      state_q;
	itaf_state_t      state_d;
	logic [DIG_W-1:0] dig_q;
	logic [PW-1:0]    bin_q;
	logic [CW-1:0]    cnt_q;
	logic [IW-1:0]    idx_q;
	logic             neg_q;
	logic             ovalid_q;
	logic [7:0]       char_q;
	logic             last_q;

	logic             out_free;
	logic             out_we;
	logic [7:0]       out_char;
	logic             out_last;
	logic [DIG_W-1:0] conv_dig;
	logic [PW-1:0]    conv_bin;
	logic [IW-1:0]    top_idx;
	logic [3:0]       cur_digit;

	assign out_free  = !ovalid_q || pop;
	assign cur_digit = dig_q[idx_q*4 +: 4];
	assign empty     = !ovalid_q;
	assign char_code = char_q;
	assign last      = last_q;

	// Four shift-and-add-3 steps of the binary to BCD conversion.
	always_comb begin
		conv_dig = dig_q;
		conv_bin = bin_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int i = 0; i < NDIG; i++) begin
				if (conv_dig[i*4 +: 4] >= BCD_ADJ_MIN) begin
					conv_dig[i*4 +: 4] = conv_dig[i*4 +: 4] + BCD_ADJ;
				end
			end
			conv_dig = {conv_dig[DIG_W-2:0], conv_bin[PW-1]};
			conv_bin = {conv_bin[PW-2:0], 1'b0};
		end
	end

	// Position of the most significant nonzero digit; zero when all are zero.
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (dig_q[i*4 +: 4] != 4'd0) begin
				top_idx = IW'(i);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_ctl.hex ? ST_SCAN : ST_CONV;
				end
			end
			ST_CONV: begin
				if (cnt_q == CW'(1)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free && idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		q_take   = 1'b0;
		out_we   = 1'b0;
		out_char = CHAR_ZERO;
		out_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_take = q_valid;
			end
			ST_SIGN: begin
				out_we   = out_free;
				out_char = CHAR_MINUS;
			end
			ST_EMIT: begin
				out_we   = out_free;
				out_char = digit_char(cur_digit);
				out_last = (idx_q == '0);
			end
			default: begin
				q_take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_we) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
			if (q_take) begin
				cnt_q <= CW'(STEPS);
			end else if (state_q == ST_CONV) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			neg_q <= q_ctl.neg;
			bin_q <= PW'(q_mag);
			if (q_ctl.hex) begin
				dig_q <= DIG_W'(q_mag);
			end else begin
				dig_q <= '0;
			end
		end else if (state_q == ST_CONV) begin
			dig_q <= conv_dig;
			bin_q <= conv_bin;
		end
		if (state_q == ST_SCAN) begin
			idx_q <= top_idx;
		end else if (state_q == ST_EMIT && out_we) begin
			idx_q <= idx_q - IW'(1);
		end
		if (out_we) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

endmodule

// File: design/integer_to_ascii_formatter.sv
// ------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a word as signed decimal or unsigned lowercase hex ASCII text.
// ------------------------------------------------------------------------
// Usage: the input side is a queue write port. A word (action, value) is
// taken at a clock edge where push is high and full is low. Action low reads
// value as a two's complement decimal number, action high as unsigned hex.
// The result side is a queue read port: while empty is low, char_code and
// last show the oldest character, and it is taken when pop is high.
// Characters come most significant digit first with no leading zeros, a
// leading '-' for negative decimal numbers, and last marks the final one.
// A decimal word is taken from the queue, runs through the shift-and-add-3
// loop, four bits per cycle, and has its top digit found; its characters
// then go out one per cycle while the receiver pops. A hex word skips the
// loop. The single character output register holds each character shown.
// A two-entry queue lets the next word enter while the current one is
// being converted or emitted.
// Reset clears the queue, the sequencer and the output valid flag. When the
// receiver stalls, the current character holds and the emitter waits.
// ------------------------------------------------------------------------
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 action,
	input  logic [WORD_BITS-1:0] value,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           char_code,
	output logic                 last
);
	import itaf_pkg::*;

	// Link between the classifying front end and the converting back end.
	logic                 q_valid;
	logic                 q_take;
	itaf_ctl_t            q_ctl;
	logic [WORD_BITS-1:0] q_mag;

	// High when the shown character is one the block may produce.
	logic                 char_legal;

	itaf_front #(
		.WORD_BITS(WORD_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.action  (action),
		.value   (value),
		.q_valid (q_valid),
		.q_take  (q_take),
		.q_ctl   (q_ctl),
		.q_mag   (q_mag)
	);

	itaf_back #(
		.WORD_BITS(WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_take    (q_take),
		.q_ctl     (q_ctl),
		.q_mag     (q_mag),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last      (last)
	);

	// Digits, lowercase hex letters and the minus sign are the only legal characters.
	assign char_legal = char_code inside {[CHAR_ZERO:CHAR_NINE], [CHAR_A:CHAR_F], CHAR_MINUS};

	// The back end only takes a word the queue actually holds.
	`ITAF_ASSERT_IMPLIES(a_take_valid, q_take, q_valid, "back end took from an empty queue")
	// A full queue must be offering a word to the back end.
	`ITAF_ASSERT_IMPLIES(a_full_valid, full, q_valid, "queue full but nothing offered")
	// Every shown character is a digit, a lowercase hex letter or a minus sign.
	`ITAF_ASSERT_IMPLIES(a_char_set, !empty, char_legal, "character outside the output set")
	// A minus sign is never the final character of a number.
	`ITAF_ASSERT_IMPLIES(a_sign_not_last, !empty && last, char_code != CHAR_MINUS, "minus sign as last")

endmodule

// File: sim/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench: words go in through the push side, and every character
// that is popped is compared with a character list worked out in the bench.
// ------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
	import itaf_pkg::*;

	// One expected character, with its end-of-number flag.
	typedef struct {
		logic [7:0] code;
		logic       fin;
	} char_expect_t;

	// One row of the directed table. An empty text means that the row is
	// checked against format_word; otherwise the text is the exact output.
	typedef struct {
		logic        act;
		logic [31:0] val;
		string       text;
	} dir_row_t;

	localparam int NUM_DIR    = 24;
	localparam int NUM_RANDOM = 260;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        action;
	logic [31:0] value;
	logic        empty;
	logic        pop;
	logic [7:0]  char_code;
	logic        last;

	// Text that travels with the word on the bus. It is sampled at the
	// same edge as the word, so the check block knows which rows are
	// typed in by hand.
	string word_text;

	char_expect_t pending_chars[$];
	int error_count;
	int words_dec;
	int words_hex;
	int words_neg;
	int chars_seen;

	// Extremes, every digit class, both modes, the zero word and the most
	// negative decimal value come first.
	dir_row_t dir_rows [0:NUM_DIR-1] = '{
		'{MODE_DEC, 32'h0000_0000, "0"},
		'{MODE_HEX, 32'h0000_0000, "0"},
		'{MODE_DEC, 32'h0000_0001, "1"},
		'{MODE_DEC, 32'h0000_0009, "9"},
		'{MODE_DEC, 32'h0000_000a, "10"},
		'{MODE_DEC, 32'hffff_ffff, "-1"},
		'{MODE_DEC, 32'hffff_fff6, "-10"},
		'{MODE_DEC, 32'h7fff_ffff, "2147483647"},
		'{MODE_DEC, 32'h8000_0000, "-2147483648"},
		'{MODE_DEC, 32'h8000_0001, "-2147483647"},
		'{MODE_DEC, 32'd999999999, ""},
		'{MODE_DEC, 32'd1000000000, ""},
		'{MODE_DEC, 32'h5555_5555, ""},
		'{MODE_DEC, 32'haaaa_aaaa, ""},
		'{MODE_HEX, 32'h0000_0001, "1"},
		'{MODE_HEX, 32'h0000_0009, "9"},
		'{MODE_HEX, 32'h0000_000a, "a"},
		'{MODE_HEX, 32'h0000_000f, "f"},
		'{MODE_HEX, 32'h0000_0010, "10"},
		'{MODE_HEX, 32'hffff_ffff, "ffffffff"},
		'{MODE_HEX, 32'h8000_0000, "80000000"},
		'{MODE_HEX, 32'h0abc_def0, "abcdef0"},
		'{MODE_HEX, 32'h1234_5678, "12345678"},
		'{MODE_HEX, 32'hdead_beef, "deadbeef"}
	};

	integer_to_ascii_formatter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.char_code (char_code),
		.last      (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Appends the characters of one word to the expected list. A decimal
	// word with its top bit set is negated as an unsigned number, so the
	// most negative value keeps its full magnitude of 2^31.
	function automatic void format_word(input logic act, input logic [31:0] w);
		logic         neg;
		logic [31:0]  mag;
		logic [31:0]  radix;
		logic [3:0]   nib;
		logic [7:0]   digs[$];
		char_expect_t ce;
		neg = (act == MODE_DEC) && w[31];
		mag = neg ? (~w + 32'd1) : w;
		radix = (act == MODE_HEX) ? 32'd16 : 32'd10;
		if (mag == 32'd0) begin
			digs.push_front(CHAR_ZERO);
		end
		while (mag != 32'd0) begin
			nib = 4'(mag % radix);
			if (nib < 4'd10) begin
				digs.push_front(CHAR_ZERO + {4'd0, nib});
			end else begin
				digs.push_front(CHAR_A + {4'd0, nib} - 8'd10);
			end
			mag = mag / radix;
		end
		if (neg) begin
			digs.push_front(CHAR_MINUS);
		end
		foreach (digs[i]) begin
			ce.code = digs[i];
			ce.fin = (i == digs.size() - 1);
			pending_chars.push_back(ce);
		end
	endfunction

	// Appends a hand-typed text to the expected list.
	function automatic void expect_text(input string s);
		char_expect_t ce;
		for (int i = 0; i < s.len(); i++) begin
			ce.code = s[i];
			ce.fin = (i == s.len() - 1);
			pending_chars.push_back(ce);
		end
	endfunction

	// Values that favor the interesting corners: short numbers, small
	// negatives, powers of two and of ten with their neighbors, and plain
	// random words so that every bit toggles.
	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		int          sel;
		sel = $urandom_range(0, 5);
		p = 32'd1;
		case (sel)
			0: begin
				p = $urandom_range(0, 99);
			end
			1: begin
				p = -$urandom_range(1, 1000);
			end
			2: begin
				p = (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 32'd1;
			end
			3: begin
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				p = p + $urandom_range(0, 2) - 32'd1;
			end
			default: begin
				p = $urandom;
			end
		endcase
		return p;
	endfunction

	// Puts one word on the bus after a random gap and holds it until the
	// block takes it. With a zero gap push simply stays high, so it is
	// never lowered and raised at the same edge.
	task automatic send_word(input logic act, input logic [31:0] val,
			input string text, input bit may_idle);
		int gap;
		gap = may_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		value <= val;
		word_text <= text;
		do @(posedge clk); while (full);
		if (act == MODE_HEX) begin
			words_hex++;
		end else begin
			words_dec++;
			if (val[31]) begin
				words_neg++;
			end
		end
	endtask

	// Every input is known from time zero; reset is released on a rising
	// edge like all other driven inputs.
	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		action = MODE_DEC;
		value = 32'd0;
		word_text = "";
		error_count = 0;
		words_dec = 0;
		words_hex = 0;
		words_neg = 0;
		chars_seen = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Sender: the directed table, a pause until the block has drained,
	// then the random words. Idling is switched off in some stretches so
	// that back-to-back words also occur.
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		for (int i = 0; i < NUM_DIR; i++) begin
			send_word(dir_rows[i].act, dir_rows[i].val, dir_rows[i].text, (i % 8) < 5);
		end
		// Let the block run dry once before the random part starts.
		push <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		for (int i = 0; i < NUM_RANDOM; i++) begin
			send_word(1'($urandom_range(0, 1)), pick_value(), "", (i % 64) < 44);
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		// The block is empty by now; any stray character would show up
		// in the check block during this tail.
		repeat (30) @(posedge clk);
		$display("Formatted %0d decimal words (%0d negative) and %0d hex words,",
			words_dec, words_neg, words_hex);
		$display("%0d characters checked, %0d mismatches.", chars_seen, error_count);
		if (error_count == 0) begin
			$display("integer_to_ascii_formatter verification clean");
		end else begin
			$display("integer_to_ascii_formatter verification failed");
		end
		$finish;
	end

	// Receiver: stalls a random number of cycles before each character,
	// with stretches where it pops on every cycle. A zero stall keeps pop
	// high across characters.
	initial begin
		int stall;
		int n;
		n = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = ((n % 90) < 60) ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			n++;
		end
	end

	// Check block. A word taken at this edge adds its characters to the
	// back of the list; a character taken at this edge is compared with the
	// front. Both are sampled before the block's own updates of this edge.
	always @(posedge clk) begin
		char_expect_t ce;
		if (arst_n) begin
			if (push && !full) begin
				if (word_text.len() != 0) begin
					expect_text(word_text);
				end else begin
					format_word(action, value);
				end
			end
			if (pop && !empty) begin
				chars_seen++;
				if (pending_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, got %h last %b",
						$time, char_code, last);
					error_count++;
				end else begin
					ce = pending_chars.pop_front();
					if (char_code !== ce.code || last !== ce.fin) begin
						$display("%0t: character mismatch: expected %h last %b, got %h last %b",
							$time, ce.code, ce.fin, char_code, last);
						error_count++;
					end
				end
			end
		end
	end

	// Hard stop far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("%0t: timeout with %0d characters outstanding", $time, pending_chars.size());
		$display("integer_to_ascii_formatter verification failed");
		$finish;
	end

endmodule
